@@ src/vd_pkg.sv @@
// Package for the K=7 rate-1/2 hard-decision Viterbi decoder.
// Holds the branch score helper and the code taps; no dependencies.
package vd_pkg;

  localparam int NumStates = 64;
  localparam int TableLen = 64;
  localparam logic [6:0] TapsA = 7'h6D;
  localparam logic [6:0] TapsB = 7'h4F;
  localparam logic [1:0] SymErased = 2'd2;

  // Score one branch: one point per symbol that agrees, erasures score nothing
  function automatic logic [1:0] branch_score(input logic [6:0] w,
                                              input logic [1:0] r0,
                                              input logic [1:0] r1);
    logic a;
    logic b;
    a = (r0 < SymErased) && (r0[0] == ^(w & TapsA));
    b = (r1 < SymErased) && (r1[0] == ^(w & TapsB));
    return {1'b0, a} + {1'b0, b};
  endfunction

endpackage

@@ src/vd_surv_mem.sv @@
// Survivor store: one column of 64 decision bits per step.
// One write port, one registered read port; depends on nothing else.
module vd_surv_mem #(
  parameter int Depth = 64,
  parameter int AddrBits = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrBits-1:0] waddr,
  input  logic [63:0]         wdata,
  input  logic [AddrBits-1:0] raddr,
  output logic [63:0]         rdata
);

  logic [63:0] mem [Depth];

  // Write and read the column store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/vd_metric_mem.sv @@
// Path metric store: 64 rows of two metrics (states 2p and 2p+1), 32 rows per bank.
// Ping-pong banks so a step reads the old set and writes the new one.
module vd_metric_mem #(
  parameter int MetricWidth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [5:0]               waddr,
  input  logic [2*MetricWidth-1:0] wdata,
  input  logic [5:0]               raddr_a,
  input  logic [5:0]               raddr_b,
  output logic [2*MetricWidth-1:0] rdata_a,
  output logic [2*MetricWidth-1:0] rdata_b
);

  logic [2*MetricWidth-1:0] mem [64];

  // Write one row, read two rows
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ src/viterbi_decoder_k7_rate_half_unit.sv @@
// Viterbi decoder, K=7, rate 1/2, hard decision, 64 states.
// Per word: an accept cycle, ACS with one butterfly a cycle through the registered read pipe,
// a best-state scan over all 64 states and a decision step.
// A regular burst adds a traceback over TbDepth columns, then collects 16 bits and sends
// them; a flush of n bits traces back and sends n bits. Output stalls lengthen the send.
// Reset (rst, synchronous) clears control state and sets start_bias to 13.
module viterbi_decoder_k7_rate_half_unit #(
  parameter int TbDepth = 48,
  parameter int DecodeLen = 16,
  parameter int MetricWidth = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [1:0] symbol_first, [3:2] symbol_second, [7:4] 0
  input  logic       s_axis_tlast,   // end_of_block
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] decoded_bit, [7:1] 0
  output logic       m_axis_tlast,   // burst_last
  output logic       m_axis_tuser,   // block_done
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int TableLen = vd_pkg::TableLen;
  localparam int EffDepth = (TbDepth + DecodeLen <= TableLen) ? TbDepth
                                                                : TableLen - DecodeLen;
  localparam int FirstCount = EffDepth + DecodeLen;
  localparam int PosBits = $clog2(TableLen);
  localparam int CntBits = 7;
  localparam logic [MetricWidth-1:0] Half = {1'b1, {(MetricWidth-1){1'b0}}};

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ACS   = 7'b0000010,
    ST_BEST  = 7'b0000100,
    ST_SKIP  = 7'b0001000,
    ST_EMIT  = 7'b0010000,
    ST_OUT   = 7'b0100000,
    ST_WAIT  = 7'b1000000
  } state_t;

  state_t state;
  logic [7:0] start_bias;
  logic [PosBits-1:0] wpos;
  logic [CntBits-1:0] steps;
  logic filled;
  logic bank;            // which metric bank holds the current set
  logic fresh;           // read metrics as block start values
  logic [1:0] r0, r1;
  logic eob;
  logic [5:0] rcnt;      // butterfly read index
  logic [1:0] rvalid;    // read pipe valid bits
  logic [4:0] p_d;       // butterfly index at memory output
  logic [63:0] dec;
  logic [6:0] bcnt;      // best scan index
  logic [5:0] best;
  logic [MetricWidth-1:0] best_m;
  logic [5:0] cur;
  logic [6:0] k;         // columns consumed
  logic [6:0] skip_left;
  logic [6:0] count;     // bits to emit
  logic [6:0] ecnt;
  logic done_flag;
  logic [63:0] bits;     // emitted bits by index
  logic tb_pend;         // survivor read in flight
  logic [6:0] ocnt;

  assign cfg_ready = (state == ST_IDLE);
  assign s_axis_tready = (state == ST_IDLE) && !cfg_valid;

  function automatic logic beats(input logic [MetricWidth-1:0] a,
                                 input logic [MetricWidth-1:0] b);
    logic [MetricWidth-1:0] d;
    d = a - b;
    return (d != '0) && (d < Half);
  endfunction

  // Metric memory: row p of bank b holds states 2p, 2p+1
  logic mwe;
  logic [5:0] mwaddr, mra, mrb;
  logic [2*MetricWidth-1:0] mwdata, mda, mdb;
  vd_metric_mem #(.MetricWidth(MetricWidth)) u_metric (
    .clk(clk), .we(mwe), .waddr(mwaddr), .wdata(mwdata),
    .raddr_a(mra), .raddr_b(mrb), .rdata_a(mda), .rdata_b(mdb)
  );

  // Survivor memory
  logic swe;
  logic [PosBits-1:0] sraddr;
  logic [63:0] srdata;
  vd_surv_mem #(.Depth(TableLen), .AddrBits(PosBits)) u_surv (
    .clk(clk), .we(swe), .waddr(wpos), .wdata(dec), .raddr(sraddr), .rdata(srdata)
  );

  // Butterfly p reads predecessors p and p+32, writes states 2p and 2p+1
  logic [4:0] rp;
  logic rd_best;
  assign rp = rcnt[4:0];
  assign rd_best = (state == ST_BEST);
  always_comb begin
    mra = {bank, rp >> 1};
    mrb = {bank, 5'(5'd16 + (rp >> 1))};
    if (rd_best) begin
      mra = {bank, bcnt[5:1]};
    end
  end

  // ACS datapath on the registered rows
  logic [MetricWidth-1:0] m_lo, m_hi;
  logic [MetricWidth-1:0] n0, n1;
  logic d0, d1;
  logic [5:0] plo, phi;
  always_comb begin
    logic [MetricWidth-1:0] lo0, hi0, lo1, hi1;
    m_lo = p_d[0] ? mda[2*MetricWidth-1:MetricWidth] : mda[MetricWidth-1:0];
    m_hi = p_d[0] ? mdb[2*MetricWidth-1:MetricWidth] : mdb[MetricWidth-1:0];
    if (fresh) begin
      m_lo = (p_d == 5'd0) ? MetricWidth'(start_bias) : '0;
      m_hi = '0;
    end
    plo = {1'b0, p_d};
    phi = {1'b1, p_d};
    lo0 = m_lo + MetricWidth'(vd_pkg::branch_score({plo, 1'b0}, r0, r1));
    hi0 = m_hi + MetricWidth'(vd_pkg::branch_score({phi, 1'b0}, r0, r1));
    lo1 = m_lo + MetricWidth'(vd_pkg::branch_score({plo, 1'b1}, r0, r1));
    hi1 = m_hi + MetricWidth'(vd_pkg::branch_score({phi, 1'b1}, r0, r1));
    // even state: inner is hi; odd state: inner is lo
    d0 = !beats(lo0, hi0);
    n0 = d0 ? hi0 : lo0;
    d1 = beats(hi1, lo1);
    n1 = d1 ? hi1 : lo1;
  end

  assign mwe = (state == ST_ACS) && rvalid[1];
  assign mwaddr = {~bank, p_d};
  assign mwdata = {n1, n0};
  assign swe = (state == ST_BEST) && (bcnt == 7'd0);

  // Best-state scan value
  logic [MetricWidth-1:0] scan_m;
  logic [5:0] scan_s;
  assign scan_m = scan_s[0] ? mda[2*MetricWidth-1:MetricWidth] : mda[MetricWidth-1:0];

  // Traceback read address
  assign sraddr = PosBits'(wpos - PosBits'(1) - PosBits'(k));

  logic is_burst;
  assign is_burst = (!filled && steps == CntBits'(FirstCount))
                 || (filled && steps == CntBits'(DecodeLen));

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      start_bias <= 8'd13;
      wpos <= '0;
      steps <= '0;
      filled <= 1'b0;
      bank <= 1'b0;
      rvalid <= '0;
      m_axis_tvalid <= 1'b0;
      tb_pend <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            start_bias <= cfg_data;
          end else if (s_axis_tvalid) begin
            r0 <= s_axis_tdata[1:0];
            r1 <= s_axis_tdata[3:2];
            eob <= s_axis_tlast;
            fresh <= !filled && steps == '0;
            rcnt <= '0;
            rvalid <= '0;
            state <= ST_ACS;
          end
        end
        ST_ACS: begin
          rcnt <= rcnt + 6'd1;
          rvalid <= {rvalid[0], !rcnt[5]};
          p_d <= rp;
          if (mwe) begin
            dec[{p_d, 1'b0}] <= d0;
            dec[{p_d, 1'b1}] <= d1;
          end
          if (rvalid == 2'b10 && rcnt[5]) begin
            bank <= ~bank;
            bcnt <= '0;
            scan_s <= '0;
            state <= ST_BEST;
          end
        end
        ST_BEST: begin
          // one state per cycle; read data comes back in the cycle after its address
          bcnt <= bcnt + 7'd1;
          scan_s <= bcnt[5:0];
          if (bcnt == 7'd1) begin
            best <= 6'd0;
            best_m <= scan_m;
          end else if (bcnt != 7'd0 && beats(scan_m, best_m)) begin
            best <= scan_s;
            best_m <= scan_m;
          end
          if (bcnt == 7'd64) begin
            wpos <= wpos + PosBits'(1);
            steps <= steps + CntBits'(1);
            fresh <= 1'b0;
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          // final compare of state 63 was folded in; choose the action
          k <= '0;
          ecnt <= '0;
          if (eob) begin
            count <= filled ? 7'(EffDepth) + steps : steps;
            skip_left <= '0;
            done_flag <= 1'b1;
            cur <= best;
            state <= ST_EMIT;
          end else if (is_burst) begin
            count <= 7'(DecodeLen);
            skip_left <= 7'(EffDepth);
            done_flag <= 1'b0;
            cur <= best;
            state <= ST_SKIP;
          end else begin
            state <= ST_IDLE;
          end
          tb_pend <= 1'b0;
        end
        ST_SKIP: begin
          if (skip_left == '0) begin
            state <= ST_EMIT;
          end else if (!tb_pend) begin
            tb_pend <= 1'b1;
          end else begin
            cur <= {srdata[cur], cur[5:1]};
            k <= k + 7'd1;
            skip_left <= skip_left - 7'd1;
            tb_pend <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (!tb_pend) begin
            bits[6'(count - 7'd1 - ecnt)] <= cur[0];
            if (ecnt + 7'd1 == count) begin
              ocnt <= '0;
              state <= ST_OUT;
            end else begin
              tb_pend <= 1'b1;
            end
          end else begin
            cur <= {srdata[cur], cur[5:1]};
            k <= k + 7'd1;
            ecnt <= ecnt + 7'd1;
            tb_pend <= 1'b0;
          end
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            if (m_axis_tvalid && ocnt == count) begin
              m_axis_tvalid <= 1'b0;
              if (done_flag) begin
                wpos <= '0;
                steps <= '0;
                filled <= 1'b0;
              end else begin
                filled <= 1'b1;
                steps <= '0;
              end
              state <= ST_IDLE;
            end else if (ocnt != count) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tdata <= {7'd0, bits[ocnt[5:0]]};
              m_axis_tlast <= (ocnt + 7'd1 == count);
              m_axis_tuser <= done_flag;
              ocnt <= ocnt + 7'd1;
            end else begin
              m_axis_tvalid <= 1'b0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready) else $error("input taken while busy");
  a_out_in_burst: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (state == ST_OUT)) else $error("output outside burst");
  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACS) && $past(state) == ST_ACS |-> $stable(bank) || rcnt[5])
    else $error("bank flipped mid-step");

endmodule
